[rtl/nsfe_pkg.sv]
// Shared types, constants and lookup functions for the NMEA sentence field extractor.
// Used by the channel interfaces, the parser core, the output stage and the top level.
package nsfe_pkg;

   localparam int PACKET_LEN = 80;

   localparam int CHAR_W  = 8;
   localparam int KIND_W  = 2;
   localparam int DEST_W  = 4;
   localparam int INDEX_W = 7;
   localparam int POS_W   = 7;
   localparam int FIELD_W = 4;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [DEST_W-1:0]  dest_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [FIELD_W-1:0] field_type;

   localparam kind_type KIND_UNKNOWN = 2'd0;
   localparam kind_type KIND_GGA     = 2'd1;
   localparam kind_type KIND_RMC     = 2'd2;

   localparam dest_type DEST_TIME     = 4'd0;
   localparam dest_type DEST_FIX      = 4'd1;
   localparam dest_type DEST_ALTITUDE = 4'd2;
   localparam dest_type DEST_LAT      = 4'd3;
   localparam dest_type DEST_NS       = 4'd4;
   localparam dest_type DEST_LONG     = 4'd5;
   localparam dest_type DEST_EW       = 4'd6;
   localparam dest_type DEST_SPEED    = 4'd7;
   localparam dest_type DEST_HEADING  = 4'd8;
   localparam dest_type DEST_DATE     = 4'd9;
   localparam dest_type NO_DEST       = 4'd15;

   localparam char_type  COMMA       = 8'h2C;
   localparam pos_type   TAG_LAST    = 7'd4;
   localparam pos_type   SKIP_OFFSET = 7'd5;
   localparam pos_type   FIRST_FIELD_OFFSET  = 7'd6;
   localparam pos_type   SECOND_FIELD_OFFSET = 7'd7;
   localparam field_type LAST_FIELD  = 4'd8;
   localparam index_type INDEX_MAX   = 7'h7F;

   typedef struct packed {
      logic      is_kind;
      kind_type  kind;
      dest_type  dest;
      index_type char_index;
      char_type  out_char;
   } result_type;

   function automatic char_type gga_tag_char(input logic [2:0] p);
      char_type c;
      case (p)
         3'd0:    c = 8'h47;  // G
         3'd1:    c = 8'h50;  // P
         3'd2:    c = 8'h47;  // G
         3'd3:    c = 8'h47;  // G
         default: c = 8'h41;  // A
      endcase
      return c;
   endfunction

   function automatic char_type rmc_tag_char(input logic [2:0] p);
      char_type c;
      case (p)
         3'd0:    c = 8'h47;  // G
         3'd1:    c = 8'h50;  // P
         3'd2:    c = 8'h52;  // R
         3'd3:    c = 8'h4D;  // M
         default: c = 8'h43;  // C
      endcase
      return c;
   endfunction

   function automatic dest_type gga_dest(input field_type f);
      dest_type d;
      case (f)
         4'd0:    d = DEST_TIME;
         4'd5:    d = DEST_FIX;
         4'd8:    d = DEST_ALTITUDE;
         default: d = NO_DEST;
      endcase
      return d;
   endfunction

   function automatic dest_type rmc_dest(input field_type f);
      dest_type d;
      case (f)
         4'd2:    d = DEST_LAT;
         4'd3:    d = DEST_NS;
         4'd4:    d = DEST_LONG;
         4'd5:    d = DEST_EW;
         4'd6:    d = DEST_SPEED;
         4'd7:    d = DEST_HEADING;
         4'd8:    d = DEST_DATE;
         default: d = NO_DEST;
      endcase
      return d;
   endfunction

   function automatic kind_type kind_of(input logic gga, input logic rmc);
      kind_type k;
      if (gga) begin
         k = KIND_GGA;
      end else if (rmc) begin
         k = KIND_RMC;
      end else begin
         k = KIND_UNKNOWN;
      end
      return k;
   endfunction

endpackage

[rtl/nsfe_channels.sv]
// Valid/ready channel interfaces for the character input and the result output.
// Depends on nsfe_pkg for the payload widths.
interface nsfe_req_if;
   import nsfe_pkg::*;

   logic     valid;
   logic     ready;
   char_type ch;
   logic     first;

   modport source (output valid, output ch, output first, input ready);
   modport sink   (input valid, input ch, input first, output ready);
endinterface

interface nsfe_rsp_if;
   import nsfe_pkg::*;

   logic      valid;
   logic      ready;
   logic      is_kind;
   kind_type  kind;
   dest_type  dest;
   index_type char_index;
   char_type  out_char;

   modport source (output valid, output is_kind, output kind, output dest,
                   output char_index, output out_char, input ready);
   modport sink   (input valid, input is_kind, input kind, input dest,
                   input char_index, input out_char, output ready);
endinterface

[rtl/nmea_sentence_field_extractor.sv]
// Top level of the NMEA GGA/RMC sentence field extractor.
// Depends on nsfe_pkg, the channel interfaces, nsfe_parser and nsfe_out_stage.
//
// Usage:
//   req carries one sentence character per transfer (ch), starting at the talker
//   id without the dollar sign; first marks the first character of a sentence.
//   rsp carries results: a kind report after the fifth character, then the
//   characters of the wanted fields with a destination code and their index.
//   Each character produces zero or one result.
// Timing:
//   One character is accepted every cycle while req.ready is high. A result is
//   registered into the result register, or into the skid entry while rsp is stalled;
//   the state update and field selection are combinational before those registers.
// Reset:
//   After reset the parser is idle and ignores characters until one arrives
//   with first set. No results are pending.
// Stalls:
//   The result register is backed by one skid entry. While rsp is stalled a
//   further character is still taken; req.ready drops only when both entries
//   hold results, and rises again the cycle after rsp takes one.
module nmea_sentence_field_extractor (
   input logic        clock,
   input logic        reset,
   nsfe_req_if.sink   req,
   nsfe_rsp_if.source rsp
);
   import nsfe_pkg::*;

   logic       step;
   logic       res_valid;
   result_type res;
   logic       space;

   assign req.ready = space;
   assign step      = req.valid && space;

   nsfe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .ch        (req.ch),
      .first     (req.first),
      .res_valid (res_valid),
      .res       (res)
   );

   nsfe_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .push      (step && res_valid),
      .push_data (res),
      .space     (space),
      .rsp       (rsp)
   );

endmodule

[rtl/nsfe_parser.sv]
// Per-character sentence parser: prefix match, field split and field selection.
// Depends on nsfe_pkg; produces at most one result per accepted character.
module nsfe_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  nsfe_pkg::char_type   ch,
   input  logic                 first,
   output logic                 res_valid,
   output nsfe_pkg::result_type res
);
   import nsfe_pkg::*;

   pos_type   position_ff, position_in;
   logic      match_gga_ff, match_gga_in;
   logic      match_rmc_ff, match_rmc_in;
   field_type field_number_ff, field_number_in;
   index_type index_ff, index_in;
   logic      first_was_comma_ff, first_was_comma_in;
   logic      halted_ff, halted_in;

   pos_type   pos;
   logic      mg, mr, fwc, hlt;
   field_type fn;
   index_type idx;
   dest_type  d;

   always_comb begin
      pos = position_ff;
      mg  = match_gga_ff;
      mr  = match_rmc_ff;
      fn  = field_number_ff;
      idx = index_ff;
      fwc = first_was_comma_ff;
      hlt = halted_ff;
      // A first flag restarts parsing, even in the middle of a sentence.
      if (first) begin
         pos = '0;
         mg  = 1'b1;
         mr  = 1'b1;
         fn  = '0;
         idx = '0;
         fwc = 1'b0;
         hlt = 1'b0;
      end

      position_in        = pos;
      match_gga_in       = mg;
      match_rmc_in       = mr;
      field_number_in    = fn;
      index_in           = idx;
      first_was_comma_in = fwc;
      halted_in          = hlt;
      res_valid          = 1'b0;
      res                = '0;
      d                  = mg ? gga_dest(fn) : rmc_dest(fn);

      if (hlt || (pos >= POS_W'(PACKET_LEN))) begin
         halted_in = 1'b1;
      end else begin
         position_in = pos + 7'd1;
         if (position_in >= POS_W'(PACKET_LEN)) begin
            halted_in = 1'b1;
         end
         if (pos <= TAG_LAST) begin
            if (ch != gga_tag_char(pos[2:0])) begin
               match_gga_in = 1'b0;
            end
            if (ch != rmc_tag_char(pos[2:0])) begin
               match_rmc_in = 1'b0;
            end
            if (pos == TAG_LAST) begin
               if (!match_gga_in && !match_rmc_in) begin
                  halted_in = 1'b1;
               end
               res_valid   = 1'b1;
               res.is_kind = 1'b1;
               res.kind    = kind_of(match_gga_in, match_rmc_in);
            end
         end else if (pos == SKIP_OFFSET) begin
            // The separator after the sentence name is skipped.
         end else if (ch == COMMA) begin
            if (pos == FIRST_FIELD_OFFSET) begin
               first_was_comma_in = 1'b1;
            end
            // Two leading commas mean an empty sentence.
            if ((pos == SECOND_FIELD_OFFSET) && fwc) begin
               halted_in = 1'b1;
            end else if (fn >= LAST_FIELD) begin
               halted_in = 1'b1;
            end else begin
               field_number_in = fn + 4'd1;
               index_in        = '0;
            end
         end else begin
            if (idx != INDEX_MAX) begin
               index_in = idx + 7'd1;
            end
            if (d != NO_DEST) begin
               res_valid      = 1'b1;
               res.is_kind    = 1'b0;
               res.kind       = kind_of(mg, mr);
               res.dest       = d;
               res.char_index = idx;
               res.out_char   = ch;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff        <= POS_W'(PACKET_LEN);
         match_gga_ff       <= 1'b0;
         match_rmc_ff       <= 1'b0;
         field_number_ff    <= '0;
         index_ff           <= '0;
         first_was_comma_ff <= 1'b0;
         halted_ff          <= 1'b1;
      end else if (step) begin
         position_ff        <= position_in;
         match_gga_ff       <= match_gga_in;
         match_rmc_ff       <= match_rmc_in;
         field_number_ff    <= field_number_in;
         index_ff           <= index_in;
         first_was_comma_ff <= first_was_comma_in;
         halted_ff          <= halted_in;
      end
   end

endmodule

[rtl/nsfe_out_stage.sv]
// Result register with a skid entry, so a waiting result does not stop input.
// Depends on nsfe_pkg and the nsfe_rsp_if interface.
module nsfe_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  nsfe_pkg::result_type push_data,
   output logic                 space,
   nsfe_rsp_if.source           rsp
);
   import nsfe_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop   = main_valid_ff && rsp.ready;
   assign space = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // No push can arrive while the skid entry is full.
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_in = push;
         main_in       = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid      = main_valid_ff;
   assign rsp.is_kind    = main_ff.is_kind;
   assign rsp.kind       = main_ff.kind;
   assign rsp.dest       = main_ff.dest;
   assign rsp.char_index = main_ff.char_index;
   assign rsp.out_char   = main_ff.out_char;

endmodule

[dv/nsfe_field_checker_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the NMEA sentence field extractor: a parser model and the queue of results
// it expects. Depends on nsfe_pkg for the result layout, codes and offsets.
package nsfe_field_checker_pkg;
   import nsfe_pkg::*;

   class sentence_field_checker;
      localparam int MAX_REPORTS = 10;

      // Parser state, kept in step with every accepted character.
      pos_type   pos;
      bit        gga_ok;
      bit        rmc_ok;
      field_type field_idx;
      index_type char_pos;
      bit        lead_comma;
      bit        stopped;

      string    gga_word;
      string    rmc_word;
      dest_type gga_map [9];
      dest_type rmc_map [9];

      result_type  expected_fields [$];
      int unsigned mismatches;

      function new();
         gga_word = "GPGGA";
         rmc_word = "GPRMC";
         gga_map = '{DEST_TIME, NO_DEST, NO_DEST, NO_DEST, NO_DEST,
                     DEST_FIX, NO_DEST, NO_DEST, DEST_ALTITUDE};
         rmc_map = '{NO_DEST, NO_DEST, DEST_LAT, DEST_NS, DEST_LONG,
                     DEST_EW, DEST_SPEED, DEST_HEADING, DEST_DATE};
         pos = pos_type'(PACKET_LEN);
         gga_ok = 1'b0;
         rmc_ok = 1'b0;
         field_idx = '0;
         char_pos = '0;
         lead_comma = 1'b0;
         stopped = 1'b1;
         mismatches = 0;
      endfunction

      function kind_type kind_now();
         if (gga_ok) begin
            return KIND_GGA;
         end else if (rmc_ok) begin
            return KIND_RMC;
         end
         return KIND_UNKNOWN;
      endfunction

      // Advances the parser by one accepted character and queues the result it
      // causes, if any. Returns 0 when the character was ignored.
      function bit note_char(char_type c, bit is_first);
         pos_type    p;
         dest_type   d;
         result_type r;
         if (is_first) begin
            pos = '0;
            gga_ok = 1'b1;
            rmc_ok = 1'b1;
            field_idx = '0;
            char_pos = '0;
            lead_comma = 1'b0;
            stopped = 1'b0;
         end
         if (stopped || pos >= PACKET_LEN) begin
            stopped = 1'b1;
            return 1'b0;
         end
         p = pos;
         pos = pos + 1'b1;
         if (pos >= PACKET_LEN) begin
            stopped = 1'b1;
         end

         if (p <= TAG_LAST) begin
            if (c != gga_word[p]) begin
               gga_ok = 1'b0;
            end
            if (c != rmc_word[p]) begin
               rmc_ok = 1'b0;
            end
            if (p == TAG_LAST) begin
               if (!gga_ok && !rmc_ok) begin
                  stopped = 1'b1;
               end
               r = '0;
               r.is_kind = 1'b1;
               r.kind = kind_now();
               expected_fields.push_back(r);
            end
            return 1'b1;
         end
         if (p == SKIP_OFFSET) begin
            return 1'b1;
         end

         if (c == COMMA) begin
            if (p == FIRST_FIELD_OFFSET) begin
               lead_comma = 1'b1;
            end
            // Two commas right after the header mean an empty sentence.
            if (p == SECOND_FIELD_OFFSET && lead_comma) begin
               stopped = 1'b1;
            end else if (field_idx >= LAST_FIELD) begin
               stopped = 1'b1;
            end else begin
               field_idx = field_idx + 1'b1;
               char_pos = '0;
            end
            return 1'b1;
         end

         d = gga_ok ? gga_map[field_idx] : rmc_map[field_idx];
         if (d != NO_DEST) begin
            r.is_kind = 1'b0;
            r.kind = kind_now();
            r.dest = d;
            r.char_index = char_pos;
            r.out_char = c;
            expected_fields.push_back(r);
         end
         if (char_pos != INDEX_MAX) begin
            char_pos = char_pos + 1'b1;
         end
         return 1'b1;
      endfunction

      function void check_field(result_type got);
         result_type want;
         if (expected_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected result: is_kind=%0d kind=%0d dest=%0d index=%0d char=%02h",
                        got.is_kind, got.kind, got.dest, got.char_index, got.out_char);
            end
            return;
         end
         want = expected_fields.pop_front();
         if (got.is_kind !== want.is_kind || got.kind !== want.kind ||
             got.dest !== want.dest || got.char_index !== want.char_index ||
             got.out_char !== want.out_char) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("result mismatch: expected is_kind=%0d kind=%0d dest=%0d index=%0d char=%02h",
                        want.is_kind, want.kind, want.dest, want.char_index, want.out_char);
               $display("                 actual   is_kind=%0d kind=%0d dest=%0d index=%0d char=%02h",
                        got.is_kind, got.kind, got.dest, got.char_index, got.out_char);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_fields.size();
      endfunction
   endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Top level of the testbench for the NMEA sentence field extractor: clock, reset, character
// stimulus and result checking. Depends on nsfe_pkg, the channel interfaces and the checker.
module tb_top;
   import nsfe_pkg::*;
   import nsfe_field_checker_pkg::*;

   localparam int ITEM_TARGET  = 2000;
   localparam int CALM_AFTER   = 1700;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 1000000;

   logic clock;
   logic reset;

   nsfe_req_if req_if ();
   nsfe_rsp_if rsp_if ();

   nmea_sentence_field_extractor dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   sentence_field_checker fields;
   char_type              sentence [$];
   int unsigned           chars_taken = 0;
   int unsigned           cycles = 0;
   bit                    held_once = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_char(input char_type c, input bit is_first);
      if (chars_taken < CALM_AFTER && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ch <= c;
      req_if.first <= is_first;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // Every transfer counts, whether or not the parser uses the character.
      void'(fields.note_char(c, is_first));
      chars_taken++;
   endtask

   task automatic send_run(input bit flag_first);
      for (int i = 0; i < sentence.size(); i++) begin
         send_char(sentence[i], flag_first && i == 0);
      end
   endtask

   task automatic load_text(input string text);
      sentence.delete();
      for (int i = 0; i < text.len(); i++) begin
         sentence.push_back(text[i]);
      end
   endtask

   // Mostly well-formed GGA and RMC sentences with random field contents; a few
   // have a damaged header, and a few are plain noise.
   task automatic build_sentence();
      int unsigned sel;
      int unsigned nfields;
      int unsigned len;
      int unsigned pick;
      sel = $urandom_range(0, 19);
      sentence.delete();
      if (sel >= 18) begin
         repeat ($urandom_range(1, 12)) sentence.push_back(char_type'($urandom_range(0, 255)));
         return;
      end
      load_text((sel < 8 || sel == 16) ? "GPGGA" : "GPRMC");
      if (sel >= 16) begin
         sentence[$urandom_range(0, 4)] = char_type'($urandom_range(0, 255));
      end
      sentence.push_back(($urandom_range(0, 7) == 0) ? char_type'($urandom_range(0, 255)) : COMMA);
      nfields = $urandom_range(1, 11);
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) begin
            sentence.push_back(COMMA);
         end
         pick = $urandom_range(0, 15);
         len = (pick < 3) ? 0 : ((pick < 14) ? $urandom_range(1, 8) : $urandom_range(9, 45));
         repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
               sentence.push_back(char_type'($urandom_range(0, 255)));
            end else begin
               sentence.push_back(char_type'($urandom_range(8'h30, 8'h39)));
            end
         end
      end
      while (sentence.size() > 120) void'(sentence.pop_back());
   endtask

   // Result side: random ready bursts, one long hold once the block is busy,
   // and a steady ready in the last part of the run.
   initial begin
      result_type  got;
      int unsigned burst_left;
      bit          ready_next;
      burst_left = 0;
      ready_next = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.is_kind = rsp_if.is_kind;
            got.kind = rsp_if.kind;
            got.dest = rsp_if.dest;
            got.char_index = rsp_if.char_index;
            got.out_char = rsp_if.out_char;
            fields.check_field(got);
         end
         if (!held_once && chars_taken >= HOLD_AT) begin
            held_once = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            burst_left = 0;
         end
         if (burst_left == 0) begin
            if (chars_taken >= CALM_AFTER) begin
               ready_next = 1'b1;
               burst_left = 1;
            end else begin
               ready_next = ($urandom_range(0, 2) != 0);
               burst_left = (ready_next && $urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 14);
            end
         end
         rsp_if.ready <= ready_next;
         burst_left--;
      end
   end

   initial begin
      fields = new();
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.ch <= '0;
      req_if.first <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Characters before any first flag are ignored.
      load_text("GP");
      send_run(1'b0);
      // Unknown kind, then the parser stops.
      load_text("GPXYZQ");
      send_run(1'b1);
      // Empty sentence: commas at offsets 6 and 7.
      load_text("GPRMC,,,9");
      send_run(1'b1);
      // Control and high characters are field characters; the next sentence
      // cuts this one short.
      load_text("GPGGA,");
      sentence.push_back(8'h00);
      sentence.push_back(8'hFF);
      send_run(1'b1);

      while (chars_taken < ITEM_TARGET) begin
         build_sentence();
         send_run($urandom_range(0, 15) != 0);
         if ($urandom_range(0, 7) == 0) begin
            sentence.delete();
            repeat ($urandom_range(1, 3)) sentence.push_back(char_type'($urandom_range(0, 255)));
            send_run(1'b0);
         end
      end
      req_if.valid <= 1'b0;

      while (fields.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fields.mismatches == 0 && fields.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
